### sv/pbrm_pkg.sv
// Package for the protection bitmap range marker.
// Holds field widths, address layout, operation codes and the control structs.
// No dependencies.
package pbrm_pkg;

    localparam int UNITS_PER_AREA_DEF = 65536;
    localparam int MARK_WORD_BITS_DEF = 8;

    localparam int OP_W       = 2;
    localparam int ADDR_W     = 36;
    localparam int LEN_W      = 32;
    localparam int AREA_BIT   = 35;
    localparam int IDX_MSB    = 31;
    localparam int IDX_LSB    = 3;
    localparam int IDX_W      = IDX_MSB - IDX_LSB + 1;
    localparam int UNIT_SHIFT = 3;
    localparam int UNITS_W    = LEN_W - UNIT_SHIFT;

    localparam logic [OP_W-1:0] OP_CHECK    = 2'd0;
    localparam logic [OP_W-1:0] OP_PROHIBIT = 2'd1;
    localparam logic [OP_W-1:0] OP_ALLOW    = 2'd2;

    typedef struct packed {
        logic load;
        logic clr_wr;
        logic addr_load;
        logic rd;
        logic chk_cap;
        logic mk_wr;
        logic rsp_load;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic div_done;
        logic chk_act;
        logic mk_act;
        logic mk_last;
    } t_sts;

endpackage

### sv/pbrm_chan_if.sv
// Request and response channel interfaces of the range marker.
// Depends on pbrm_pkg for field widths.
interface pbrm_req_if import pbrm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] address;
    logic [LEN_W-1:0]  length_bytes;

    modport source (output valid, op, address, length_bytes, input ready);
    modport sink   (input valid, op, address, length_bytes, output ready);
endinterface

interface pbrm_rsp_if ();
    logic valid;
    logic ready;
    logic sane;
    logic out_of_range;

    modport source (output valid, sane, out_of_range, input ready);
    modport sink   (input valid, sane, out_of_range, output ready);
endinterface

### sv/pbrm_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module pbrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/pbrm_div.sv
// Divider by a constant through reciprocal multiplication, two register stages.
// Starts on load and holds quotient and remainder once done. No dependencies.
module pbrm_div #(
    parameter int DW      = 16,
    parameter int DIVISOR = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_load,
    input  logic [DW-1:0]                i_dividend,
    output logic [DW-1:0]                o_quo,
    output logic [$clog2(DIVISOR)-1:0]   o_rem,
    output logic                         o_done
);

    localparam int RW = $clog2(DIVISOR);
    localparam int SH = DW + RW;
    localparam int PW = SH + DW;
    localparam longint unsigned RECIP =
        ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);

    localparam logic [1:0] ST_QUO = 2'd2;
    localparam logic [1:0] ST_REM = 2'd1;

    logic [1:0]    r_cnt;
    logic [DW-1:0] r_dvd;
    logic [DW-1:0] r_quo;
    logic [RW-1:0] r_rem;
    logic [PW-1:0] prod;
    logic [PW-1:0] back;
    logic [DW-1:0] diff;

    assign prod = PW'(r_dvd) * PW'(RECIP);
    assign back = PW'(r_quo) * PW'(DIVISOR);
    assign diff = r_dvd - DW'(back);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= ST_QUO;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_dvd <= i_dividend;
        end else if (r_cnt == ST_QUO) begin
            r_quo <= prod[SH +: DW];
        end else if (r_cnt == ST_REM) begin
            r_rem <= RW'(diff);
        end
    end

    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
    assign o_done = (r_cnt == '0);

endmodule

### sv/pbrm_dp.sv
// Datapath: request capture, index divider, mark store and word masking.
// Depends on pbrm_pkg, pbrm_div and pbrm_ram.
module pbrm_dp import pbrm_pkg::*; #(
    parameter int UNITS_PER_AREA = UNITS_PER_AREA_DEF,
    parameter int MARK_WORD_BITS = MARK_WORD_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    input  logic [OP_W-1:0]   i_op,
    input  logic [ADDR_W-1:0] i_address,
    input  logic [LEN_W-1:0]  i_length_bytes,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    output logic              o_rsp_sane,
    output logic              o_rsp_oor
);

    localparam int W     = MARK_WORD_BITS;
    localparam int U     = UNITS_PER_AREA;
    localparam int WPA   = (U + W - 1) / W;
    localparam int DEPTH = 2 * WPA;
    localparam int AW    = $clog2(DEPTH);
    localparam int LW    = $clog2(U);
    localparam int HW    = $clog2(U + 1);
    localparam int RW    = $clog2(W);
    localparam int SW    = $clog2(W + 1);
    localparam int SUMW  = IDX_W + 1;

    logic               r_enable;
    logic [AW-1:0]      r_clr_addr;
    logic               r_area;
    logic               r_prohibit;
    logic [LW-1:0]      r_lo;
    logic [HW-1:0]      r_hi;
    logic [HW-1:0]      r_base;
    logic [AW-1:0]      r_waddr;
    logic               r_oor;
    logic               r_sane;
    logic               r_chk_act;
    logic               r_mk_act;
    logic               r_rsp_sane;
    logic               r_rsp_oor;

    logic [IDX_W-1:0]   idx_raw;
    logic [UNITS_W-1:0] units;
    logic [SUMW-1:0]    sum;
    logic               oor_start;
    logic               clip;
    logic               is_mark;
    logic [LW-1:0]      lo_new;
    logic [LW-1:0]      quo;
    logic [RW-1:0]      rem;
    logic               div_done;
    logic [HW:0]        base_w;
    logic [HW-1:0]      lo_e;
    logic [SW-1:0]      s;
    logic [SW-1:0]      e;
    logic [W-1:0]       mask;
    logic [W-1:0]       rdata;
    logic [W-1:0]       mk_data;
    logic               we;
    logic [AW-1:0]      waddr;
    logic [W-1:0]       wdata;

    assign idx_raw   = i_address[IDX_MSB:IDX_LSB];
    assign units     = i_length_bytes[LEN_W-1:UNIT_SHIFT];
    assign sum       = SUMW'(idx_raw) + SUMW'(units);
    assign oor_start = (SUMW'(idx_raw) >= SUMW'(U));
    assign clip      = (sum > SUMW'(U));
    assign is_mark   = (i_op == OP_PROHIBIT) || (i_op == OP_ALLOW);
    assign lo_new    = LW'(idx_raw);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
        end else if (i_cfg_we) begin
            r_enable <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_area     <= i_address[AREA_BIT];
            r_prohibit <= (i_op == OP_PROHIBIT);
            r_lo       <= lo_new;
            r_hi       <= clip ? HW'(U) : HW'(sum);
            r_sane     <= 1'b0;
            r_chk_act  <= (i_op == OP_CHECK) && !oor_start && r_enable;
            r_mk_act   <= is_mark && !oor_start && r_enable && (units != '0);
            if (i_op == OP_CHECK) begin
                r_oor <= oor_start;
            end else if (is_mark) begin
                r_oor <= oor_start || clip;
            end else begin
                r_oor <= 1'b0;
            end
        end
        if (i_cmd.addr_load) begin
            r_waddr <= r_area ? AW'(WPA) + AW'(quo) : AW'(quo);
            r_base  <= HW'(r_lo) - HW'(rem);
        end
        if (i_cmd.mk_wr) begin
            r_waddr <= r_waddr + AW'(1);
            r_base  <= HW'(base_w);
        end
        if (i_cmd.chk_cap) begin
            r_sane <= ~rdata[rem];
        end
        if (i_cmd.rsp_load) begin
            r_rsp_sane <= r_sane;
            r_rsp_oor  <= r_oor;
        end
    end

    pbrm_div #(
        .DW      (LW),
        .DIVISOR (W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (i_cmd.load),
        .i_dividend (lo_new),
        .o_quo      (quo),
        .o_rem      (rem),
        .o_done     (div_done)
    );

    assign base_w = {1'b0, r_base} + (HW+1)'(W);
    assign lo_e   = HW'(r_lo);
    assign s      = (lo_e > r_base) ? SW'(lo_e - r_base) : '0;
    assign e      = ({1'b0, r_hi} < base_w) ? SW'(r_hi - r_base) : SW'(W);

    always_comb begin
        for (int j = 0; j < W; j++) begin
            mask[j] = (SW'(j) >= s) && (SW'(j) < e);
        end
    end

    assign mk_data = r_prohibit ? (rdata | mask) : (rdata & ~mask);
    assign we      = i_cmd.clr_wr || i_cmd.mk_wr;
    assign waddr   = i_cmd.clr_wr ? r_clr_addr : r_waddr;
    assign wdata   = i_cmd.clr_wr ? {W{1'b1}} : mk_data;

    pbrm_ram #(
        .WIDTH (W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (i_cmd.rd),
        .i_raddr (r_waddr),
        .o_rdata (rdata)
    );

    assign o_sts.clr_last = (r_clr_addr == AW'(DEPTH - 1));
    assign o_sts.div_done = div_done;
    assign o_sts.chk_act  = r_chk_act;
    assign o_sts.mk_act   = r_mk_act;
    assign o_sts.mk_last  = ({1'b0, r_hi} <= base_w);

    assign o_rsp_sane = r_rsp_sane;
    assign o_rsp_oor  = r_rsp_oor;

endmodule

### sv/pbrm_ctrl.sv
// Controller state machine: store clearing, request sequencing, response handshake.
// Depends on pbrm_pkg for the command and status structs.
module pbrm_ctrl import pbrm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_cmd o_cmd,
    input  t_sts i_sts
);

    localparam logic [3:0] S_INIT    = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_DIV     = 4'd2;
    localparam logic [3:0] S_ADDR    = 4'd3;
    localparam logic [3:0] S_CHK_RD  = 4'd4;
    localparam logic [3:0] S_CHK_DAT = 4'd5;
    localparam logic [3:0] S_MK_RD   = 4'd6;
    localparam logic [3:0] S_MK_WR   = 4'd7;
    localparam logic [3:0] S_FIN     = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_rsp_valid;
    logic       n_rsp_valid;
    logic       out_free;

    assign out_free = !r_rsp_valid || i_rsp_ready;

    always_comb begin
        n_state     = r_state;
        n_rsp_valid = r_rsp_valid && !i_rsp_ready;
        o_cmd       = '0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_ADDR;
                end
            end
            S_ADDR: begin
                o_cmd.addr_load = 1'b1;
                if (i_sts.chk_act) begin
                    n_state = S_CHK_RD;
                end else if (i_sts.mk_act) begin
                    n_state = S_MK_RD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_CHK_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_CHK_DAT;
            end
            S_CHK_DAT: begin
                o_cmd.chk_cap = 1'b1;
                n_state       = S_FIN;
            end
            S_MK_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_MK_WR;
            end
            S_MK_WR: begin
                o_cmd.mk_wr = 1'b1;
                n_state     = i_sts.mk_last ? S_FIN : S_MK_RD;
            end
            S_FIN: begin
                if (out_free) begin
                    o_cmd.rsp_load = 1'b1;
                    n_rsp_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_rsp_valid;

endmodule

### sv/protection_bitmap_range_marker_core.sv
// Protection bitmap range marker: one mark bit per 8-byte unit for two areas.
// After reset the block sweeps all 2*ceil(UNITS_PER_AREA/MARK_WORD_BITS) words
// of the mark store (16384 at the defaults) to all ones, one word per cycle,
// before the first request is taken; the enable register can be written meanwhile.
// Each request first splits its unit index into word and bit with a reciprocal
// multiplication, quotient then remainder. A check then takes one store read.
// A prohibit or allow request does read-modify-write on the single store write port,
// a read and then a write per mark word touched; a request that touches nothing
// (disabled, start out of range, zero units, unused op) goes straight to its response.
// The next request is taken the cycle after a response is loaded, and the response
// register lets it be taken while a result waits.
// Depends on pbrm_pkg, pbrm_chan_if, pbrm_ctrl and pbrm_dp.
module protection_bitmap_range_marker_core import pbrm_pkg::*; #(
    parameter int UNITS_PER_AREA = UNITS_PER_AREA_DEF,
    parameter int MARK_WORD_BITS = MARK_WORD_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pbrm_req_if.sink   i_req,
    pbrm_rsp_if.source o_rsp,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata
);

    t_cmd cmd;
    t_sts sts;

    pbrm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    pbrm_dp #(
        .UNITS_PER_AREA (UNITS_PER_AREA),
        .MARK_WORD_BITS (MARK_WORD_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_op           (i_req.op),
        .i_address      (i_req.address),
        .i_length_bytes (i_req.length_bytes),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_rsp_sane     (o_rsp.sane),
        .o_rsp_oor      (o_rsp.out_of_range)
    );

endmodule

### sv/pbrm_checker.sv
// Port-level assertions for the range marker, bound to the top level.
// No dependencies beyond the top level's ports.
module pbrm_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input logic i_req_ready,
    input logic i_rsp_valid,
    input logic i_rsp_ready,
    input logic i_rsp_sane,
    input logic i_rsp_oor
);

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_req_ready && !i_rsp_valid)
        else $error("request ready or response valid right after reset");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && i_rsp_valid && !i_rsp_ready) |=>
            i_rsp_valid && $stable(i_rsp_sane) && $stable(i_rsp_oor))
        else $error("stalled response dropped or changed");

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && i_req_valid && i_req_ready) |=> !i_req_ready && !$rose(i_rsp_valid))
        else $error("request taken or response raised in the cycle after a transfer");

    a_sane_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> !(i_rsp_sane && i_rsp_oor))
        else $error("response sane for an out-of-range index");

endmodule

bind protection_bitmap_range_marker_core pbrm_checker u_pbrm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_sane  (o_rsp.sane),
    .i_rsp_oor   (o_rsp.out_of_range)
);

### tb/protection_bitmap_range_marker_core_tb.sv
// Testbench for protection_bitmap_range_marker_core: check, prohibit and allow requests
// against a scoreboard that keeps its own copy of the mark store and the enable bit.
// Depends on pbrm_pkg, pbrm_chan_if and the core with its submodules.
`timescale 1ns / 1ps

module protection_bitmap_range_marker_core_tb;
    import pbrm_pkg::*;

    localparam int UNITS = UNITS_PER_AREA_DEF;
    localparam int WBITS = MARK_WORD_BITS_DEF;
    localparam int WORDS = (UNITS + WBITS - 1) / WBITS;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_CHUNKS = 10;
    localparam int CHUNK_ITEMS   = 103;
    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] address;
        logic [LEN_W-1:0]  length_bytes;
    } mark_request_t;

    typedef struct packed {
        logic sane;
        logic out_of_range;
    } mark_result_t;

    class mark_scoreboard;
        bit [WBITS-1:0] marks [2*WORDS];
        bit             enabled;
        mark_result_t   pending_results [$];
        int unsigned    requests, results, sane_count, oor_count, errors;

        function new();
            foreach (marks[i]) marks[i] = '1;
            enabled = 1'b0;
        endfunction

        function void note_request(mark_request_t rq);
            longint unsigned idx, stop, w, base, lo_b, hi_b, b;
            int unsigned     area;
            bit [WBITS-1:0]  mask;
            mark_result_t    exp;
            exp  = '0;
            area = 32'(rq.address[AREA_BIT]);
            idx  = 64'(rq.address[IDX_MSB:IDX_LSB]);
            stop = idx + 64'(rq.length_bytes >> UNIT_SHIFT);
            requests++;
            if (rq.op == OP_CHECK || rq.op == OP_PROHIBIT || rq.op == OP_ALLOW) begin
                if (idx >= 64'(UNITS)) begin
                    exp.out_of_range = 1'b1;
                end else if (rq.op == OP_CHECK) begin
                    exp.sane = enabled && !marks[area*WORDS + idx/WBITS][idx%WBITS];
                end else begin
                    if (stop > 64'(UNITS)) begin
                        stop = 64'(UNITS);
                        exp.out_of_range = 1'b1;
                    end
                    if (enabled) begin
                        for (w = idx / WBITS; w * WBITS < stop; w++) begin
                            base = w * WBITS;
                            lo_b = (idx > base) ? idx - base : 0;
                            hi_b = (stop < base + WBITS) ? stop - base : WBITS;
                            mask = '0;
                            for (b = lo_b; b < hi_b; b++) mask[b] = 1'b1;
                            if (rq.op == OP_PROHIBIT)
                                marks[area*WORDS + w] |= mask;
                            else
                                marks[area*WORDS + w] &= ~mask;
                        end
                    end
                end
            end
            pending_results.push_back(exp);
        endfunction

        function void check_result(logic sane, logic out_of_range);
            mark_result_t exp;
            results++;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: result with no request waiting: sane=%0b out_of_range=%0b",
                         $time, sane, out_of_range);
                return;
            end
            exp = pending_results.pop_front();
            if (sane === 1'b1) sane_count++;
            if (out_of_range === 1'b1) oor_count++;
            if (sane !== exp.sane) begin
                errors++;
                $display("%0t: sane mismatch: expected %0b actual %0b",
                         $time, exp.sane, sane);
            end
            if (out_of_range !== exp.out_of_range) begin
                errors++;
                $display("%0t: out_of_range mismatch: expected %0b actual %0b",
                         $time, exp.out_of_range, out_of_range);
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;
    int unsigned gap_pct;
    int unsigned stall_pct;

    pbrm_req_if req_if ();
    pbrm_rsp_if rsp_if ();

    mark_scoreboard sb = new();

    protection_bitmap_range_marker_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_if),
        .o_rsp       (rsp_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Response side: random stall bursts
    initial begin
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
                rsp_if.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
            sb.check_result(rsp_if.sane, rsp_if.out_of_range);
    end

    task automatic send_request(input mark_request_t rq);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        req_if.valid        <= 1'b1;
        req_if.op           <= rq.op;
        req_if.address      <= rq.address;
        req_if.length_bytes <= rq.length_bytes;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        sb.note_request(rq);
    endtask

    task automatic send_unit(input logic [OP_W-1:0] op, input bit area,
                             input int unsigned idx, input logic [LEN_W-1:0] len);
        mark_request_t rq;
        rq = '0;
        rq.op = op;
        rq.address[AREA_BIT] = area;
        rq.address[IDX_MSB:IDX_LSB] = IDX_W'(idx);
        rq.length_bytes = len;
        send_request(rq);
    endtask

    // Drop valid, drain every outstanding result, then let the block settle
    task automatic wait_idle();
        req_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_enable(input bit value);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.enabled = value;
    endtask

    function automatic mark_request_t random_request(input bit sweep);
        mark_request_t rq;
        int unsigned   pick;
        int unsigned   idx;
        rq = '0;
        pick = $urandom_range(0, 99);
        if (pick < 44)      rq.op = OP_CHECK;
        else if (pick < 71) rq.op = OP_PROHIBIT;
        else if (pick < 98) rq.op = OP_ALLOW;
        else                rq.op = OP_UNUSED;
        pick = $urandom_range(0, 99);
        if (pick < 70)      idx = $urandom_range(0, 1023);
        else if (pick < 80) idx = UNITS - $urandom_range(1, 64);
        else                idx = $urandom_range(0, UNITS - 1);
        rq.address[AREA_BIT] = 1'($urandom_range(0, 1));
        rq.address[IDX_MSB:IDX_LSB] = IDX_W'(idx);
        rq.address[AREA_BIT-1:IDX_MSB+1] = (AREA_BIT-IDX_MSB-1)'($urandom);
        rq.address[IDX_LSB-1:0] = IDX_LSB'($urandom);
        pick = $urandom_range(0, 99);
        if (sweep) begin
            rq.length_bytes = $urandom;
        end else if (pick < 75) begin
            rq.length_bytes = $urandom_range(0, 511);
        end else if (pick < 92) begin
            rq.length_bytes = $urandom_range(0, 4095);
        end else if (pick < 96) begin
            // long range near the area end: clipped but cheap
            rq.length_bytes = $urandom;
            rq.address[IDX_MSB:IDX_LSB] = IDX_W'(UNITS - $urandom_range(1, 512));
        end else begin
            rq.length_bytes = $urandom;
            rq.address[IDX_MSB:IDX_LSB] = IDX_W'($urandom);
        end
        return rq;
    endfunction

    initial begin
        mark_request_t rq;
        int unsigned   chunk;
        int unsigned   k;
        i_rst_n             <= 1'b0;
        i_cfg_we            <= 1'b0;
        i_cfg_wdata         <= 1'b0;
        req_if.valid        <= 1'b0;
        req_if.op           <= OP_CHECK;
        req_if.address      <= '0;
        req_if.length_bytes <= '0;
        gap_pct   = 20;
        stall_pct = 5;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Disabled: checks not sane, marking ignored
        write_enable(1'b0);
        send_unit(OP_CHECK, 1'b0, 0, 0);
        send_unit(OP_ALLOW, 1'b0, 0, 64);
        send_unit(OP_CHECK, 1'b0, 0, 0);
        send_unit(OP_CHECK, 1'b0, UNITS, 0);
        send_unit(OP_ALLOW, 1'b0, UNITS - 6, 128);
        send_unit(OP_UNUSED, 1'b0, 5, 64);

        write_enable(1'b1);
        send_unit(OP_CHECK, 1'b0, 0, 0);
        send_unit(OP_ALLOW, 1'b0, 3, 160);
        send_unit(OP_CHECK, 1'b0, 3, 0);
        send_unit(OP_CHECK, 1'b0, 2, 0);
        send_unit(OP_CHECK, 1'b0, 22, 0);
        send_unit(OP_CHECK, 1'b0, 23, 0);
        send_unit(OP_ALLOW, 1'b1, 0, '1);
        send_unit(OP_CHECK, 1'b1, UNITS - 1, 0);
        send_unit(OP_CHECK, 1'b0, UNITS - 1, 0);
        send_unit(OP_PROHIBIT, 1'b1, UNITS - 1, 8);
        send_unit(OP_CHECK, 1'b1, UNITS - 1, 0);
        send_unit(OP_PROHIBIT, 1'b0, 3, 7);
        send_unit(OP_CHECK, 1'b0, 3, 0);
        rq = '0;
        rq.op = OP_CHECK;
        rq.address = '1;
        send_request(rq);
        send_unit(OP_PROHIBIT, 1'b1, 65000, '1);
        rq.op = OP_UNUSED;
        rq.length_bytes = '1;
        send_request(rq);
        rq.op = OP_CHECK;
        rq.address = 36'h7_0000_0007;
        rq.length_bytes = '0;
        send_request(rq);
        send_unit(OP_ALLOW, 1'b0, UNITS - 1, 8);
        send_unit(OP_CHECK, 1'b0, UNITS - 1, 0);

        for (chunk = 0; chunk < RANDOM_CHUNKS; chunk++) begin
            write_enable(chunk != 3 && chunk != 6);
            if (chunk == RANDOM_CHUNKS - 1) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else begin
                case ($urandom_range(0, 3))
                    0: begin gap_pct = 0;  stall_pct = 0;  end
                    1: begin gap_pct = 10; stall_pct = 3;  end
                    2: begin gap_pct = 25; stall_pct = 8;  end
                    default: begin gap_pct = 50; stall_pct = 15; end
                endcase
            end
            for (k = 0; k < CHUNK_ITEMS; k++) begin
                rq = random_request(((chunk * CHUNK_ITEMS + k) % 128) == 64);
                send_request(rq);
            end
        end

        wait_idle();
        $display("Covered %0d requests over both areas, enable on and off: %0d results,",
                 sb.requests, sb.results);
        $display("%0d answered sane, %0d flagged out of range.", sb.sane_count, sb.oor_count);
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### protection_bitmap_range_marker_core.f
sv/pbrm_pkg.sv
sv/pbrm_chan_if.sv
sv/pbrm_ram.sv
sv/pbrm_div.sv
sv/pbrm_dp.sv
sv/pbrm_ctrl.sv
sv/protection_bitmap_range_marker_core.sv
sv/pbrm_checker.sv
tb/protection_bitmap_range_marker_core_tb.sv
